// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/xtea_pkg.sv
// ---------------------------------------------------------------------------
// XTEA package
// Beat types, key set type, cipher constants and the mixing function.
// ---------------------------------------------------------------------------
package xtea_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

    typedef logic [3:0][WORD_W-1:0] key_set_t;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } xtea_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_first_word;
        logic [WORD_W-1:0] out_second_word;
    } xtea_out_t;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] x);
        mix_word = ((x << 4) ^ (x >> 5)) + x;
    endfunction

endpackage

// File: hdl/xtea_cell.sv
// ---------------------------------------------------------------------------
// XTEA half-round cell
// One registered half-round of the cipher. The round sum and key select
// are fixed by the cell's place in the chain; op picks encrypt or decrypt.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module xtea_cell #(
    parameter int ROUNDS = 32,
    parameter int STAGE  = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  xtea_pkg::key_set_t  key,
    input  logic                in_valid,
    input  xtea_pkg::xtea_in_t  in_beat,
    output logic                out_valid,
    output xtea_pkg::xtea_in_t  out_beat
);

    localparam int   ROUND       = STAGE / 2;
    localparam logic SECOND_HALF = ((STAGE % 2) == 1) ? 1'b1 : 1'b0;
    localparam int   STEP_ENC    = ROUND + (((STAGE % 2) == 1) ? 1 : 0);
    localparam int   STEP_DEC    = ROUNDS - ROUND - (((STAGE % 2) == 1) ? 1 : 0);

    localparam logic [31:0] ENC_SUM = 32'(STEP_ENC) * xtea_pkg::DELTA;
    localparam logic [31:0] DEC_SUM = 32'(STEP_DEC) * xtea_pkg::DELTA;

    // first half of an encrypt round keys on the low sum bits, second on bits 12:11
    localparam logic [1:0] ENC_IDX = SECOND_HALF ? ENC_SUM[12:11] : ENC_SUM[1:0];
    localparam logic [1:0] DEC_IDX = SECOND_HALF ? DEC_SUM[1:0] : DEC_SUM[12:11];

    logic               upd_first;
    logic [31:0]        src_word;
    logic [31:0]        tgt_word;
    logic [31:0]        round_key;
    logic [31:0]        mixed;
    logic [31:0]        tgt_new;
    xtea_pkg::xtea_in_t beat_next;
    xtea_pkg::xtea_in_t beat_reg;
    logic               valid_reg;
    logic [31:0]        out_src;

    always_comb
    begin
        upd_first = ~(in_beat.op ^ SECOND_HALF);
        src_word  = upd_first ? in_beat.second_word : in_beat.first_word;
        tgt_word  = upd_first ? in_beat.first_word : in_beat.second_word;
        round_key = (in_beat.op == xtea_pkg::OP_DECRYPT) ? (DEC_SUM + key[DEC_IDX])
                                                         : (ENC_SUM + key[ENC_IDX]);
        mixed     = xtea_pkg::mix_word(src_word) ^ round_key;
        tgt_new   = (in_beat.op == xtea_pkg::OP_DECRYPT) ? (tgt_word - mixed)
                                                         : (tgt_word + mixed);
        beat_next = in_beat;
        if (upd_first)
        begin
            beat_next.first_word = tgt_new;
        end
        else
        begin
            beat_next.second_word = tgt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // word this cell left alone, picked by the op carried with the beat
    assign out_src = ~(out_beat.op ^ SECOND_HALF) ? out_beat.second_word : out_beat.first_word;

    `ASSERT_IMPLY(a_valid_follows, clk, rst_n, out_valid, $past(in_valid), "beat out of nowhere")
    `ASSERT_IMPLY(a_op_carried, clk, rst_n, out_valid, out_beat.op == $past(in_beat.op), "op lost")
    `ASSERT_IMPLY(a_word_held, clk, rst_n, out_valid, out_src == $past(src_word), "word changed")

endmodule

// File: hdl/xtea_block_cipher.sv
// ---------------------------------------------------------------------------
// XTEA block cipher
// Pipelined 64-bit XTEA encrypt/decrypt with a 128-bit key held in four
// write-only key registers.
// ---------------------------------------------------------------------------
// channel   direction  handshake        beat
// input     in         start & !busy    op, first_word, second_word
// result    out        done (1 cycle)   out_first_word, out_second_word
// key       in         wr_en            wr_index, wr_data
//
// One block is taken every cycle; busy is always low.
// The result comes out of a chain of half-round cells, one register each.
// Reset clears the key registers to zero and empties the chain.
// The result is shown for one cycle only; the receiver cannot stall it.
// ---------------------------------------------------------------------------
module xtea_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  xtea_pkg::xtea_in_t  din,
    output logic                done,
    output xtea_pkg::xtea_out_t result,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [31:0]         wr_data
);

    localparam int LAT = 2 * ROUNDS;

    xtea_pkg::key_set_t key_reg;
    logic               valid_chain [LAT+1];
    xtea_pkg::xtea_in_t beat_chain  [LAT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (wr_en)
        begin
            key_reg[wr_index] <= wr_data;
        end
    end

    assign busy           = 1'b0;
    assign valid_chain[0] = start & ~busy;
    assign beat_chain[0]  = din;

    for (genvar s = 0; s < LAT; s++)
    begin : g_cell
        xtea_cell #(
            .ROUNDS (ROUNDS),
            .STAGE  (s)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key_reg),
            .in_valid  (valid_chain[s]),
            .in_beat   (beat_chain[s]),
            .out_valid (valid_chain[s+1]),
            .out_beat  (beat_chain[s+1])
        );
    end

    assign done                   = valid_chain[LAT];
    assign result.out_first_word  = beat_chain[LAT].first_word;
    assign result.out_second_word = beat_chain[LAT].second_word;

endmodule

// File: dv/tb_top.sv
// ---------------------------------------------------------------------------
// XTEA block cipher testbench
// Drives 64-bit blocks through the pipelined cipher under several keys and
// idle patterns. A local XTEA model predicts each result as the block is
// taken, and each done beat is checked in order against that prediction.
// ---------------------------------------------------------------------------
module tb_top;

    import xtea_pkg::*;

    localparam int ROUNDS      = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;

    localparam logic [1:0] KEY_WORD0_IDX = 2'd0;
    localparam logic [1:0] KEY_WORD1_IDX = 2'd1;
    localparam logic [1:0] KEY_WORD2_IDX = 2'd2;
    localparam logic [1:0] KEY_WORD3_IDX = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    xtea_in_t    din;
    logic        done;
    xtea_out_t   result;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [31:0] wr_data;

    key_set_t    round_keys = '0;
    xtea_out_t   expected_blocks[$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    int          sender_idle_pct = 0;

    xtea_block_cipher #(
        .ROUNDS(ROUNDS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .din      (din),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] shift_mix(input logic [31:0] x);
        logic [31:0] m;
        m = (x << 4) ^ (x >> 5);
        return m + x;
    endfunction

    // Predict the processed block under the key words currently held
    function automatic xtea_out_t cipher_block(input xtea_in_t beat);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] sum;
        int          r;
        xtea_out_t   res;
        y = beat.first_word;
        z = beat.second_word;
        if (beat.op == OP_ENCRYPT)
        begin
            sum = '0;
            for (r = 0; r < ROUNDS; r++)
            begin
                y   = y + (shift_mix(z) ^ (sum + round_keys[sum[1:0]]));
                sum = sum + DELTA;
                z   = z + (shift_mix(y) ^ (sum + round_keys[sum[12:11]]));
            end
        end
        else
        begin
            sum = DELTA * ROUNDS;
            for (r = 0; r < ROUNDS; r++)
            begin
                z   = z - (shift_mix(y) ^ (sum + round_keys[sum[12:11]]));
                sum = sum - DELTA;
                y   = y - (shift_mix(z) ^ (sum + round_keys[sum[1:0]]));
            end
        end
        res.out_first_word  = y;
        res.out_second_word = z;
        return res;
    endfunction

    function automatic xtea_in_t make_block(input logic op, input logic [31:0] a,
                                            input logic [31:0] b);
        xtea_in_t beat;
        beat.op          = op;
        beat.first_word  = a;
        beat.second_word = b;
        return beat;
    endfunction

    function automatic void report_mismatch(input string field, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch on %s: expected %08h, got %08h", field, want, got);
    endfunction

    // Predict on every taken beat, check every done beat, track key writes
    always @(posedge clk)
    begin
        xtea_out_t want;
        logic      moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (wr_en)
            begin
                round_keys[wr_index] = wr_data;
                moved = 1'b1;
            end
            if (start && !busy)
            begin
                expected_blocks.push_back(cipher_block(din));
                moved = 1'b1;
            end
            if (done)
            begin
                moved = 1'b1;
                if (expected_blocks.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result %08h %08h",
                                 result.out_first_word, result.out_second_word);
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (result.out_first_word !== want.out_first_word)
                        report_mismatch("out_first_word", want.out_first_word,
                                        result.out_first_word);
                    if (result.out_second_word !== want.out_second_word)
                        report_mismatch("out_second_word", want.out_second_word,
                                        result.out_second_word);
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_block(input xtea_in_t beat);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        din   <= beat;
        do @(posedge clk); while (busy);
    endtask

    // Drop start and wait for every outstanding result
    task automatic drain;
        start <= 1'b0;
        do @(posedge clk); while (expected_blocks.size() != 0);
    endtask

    task automatic write_key_word(input logic [1:0] idx, input logic [31:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_key(input key_set_t k);
        drain();
        write_key_word(KEY_WORD0_IDX, k[0]);
        write_key_word(KEY_WORD1_IDX, k[1]);
        write_key_word(KEY_WORD2_IDX, k[2]);
        write_key_word(KEY_WORD3_IDX, k[3]);
        wr_en <= 1'b0;
    endtask

    // Send a block, then the opposite operation on its predicted output
    task automatic send_round_trip(input xtea_in_t beat);
        xtea_out_t mid;
        mid = cipher_block(beat);
        send_block(beat);
        send_block(make_block(~beat.op, mid.out_first_word, mid.out_second_word));
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(19))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_key;
        sender_idle_pct = 0;
        send_block(make_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000));
        send_block(make_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000));
        send_block(make_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_block(make_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_corner_blocks;
        set_key({4{32'hFFFF_FFFF}});
        send_block(make_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000));
        send_block(make_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_block(make_block(OP_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF));
        send_block(make_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000));
        send_block(make_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001));
        send_round_trip(make_block(OP_ENCRYPT, 32'h7FFF_FFFF, 32'h8000_0000));
        // word order shows up if a key word lands in the wrong slot
        set_key({32'hFFFF_FFFF, 32'h0000_0000, 32'h0123_4567, 32'h89AB_CDEF});
        send_block(make_block(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF));
        send_block(make_block(OP_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF));
        send_block(make_block(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555));
        send_round_trip(make_block(OP_DECRYPT, 32'h0000_0001, 32'hFFFF_FFFE));
        send_round_trip(make_block(OP_ENCRYPT, 32'hDEAD_BEEF, 32'h0000_0000));
    endtask

    task automatic test_random_traffic(input int idle_pct, input key_set_t k,
                                       input int n_items);
        int       sent;
        xtea_in_t beat;
        set_key(k);
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < n_items)
        begin
            beat = make_block(1'($urandom_range(1)), random_word(), random_word());
            if ($urandom_range(4) == 0)
            begin
                send_round_trip(beat);
                sent += 2;
            end
            else
            begin
                send_block(beat);
                sent++;
            end
        end
    endtask

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        start    = 1'b0;
        din      = '0;
        wr_en    = 1'b0;
        wr_index = KEY_WORD0_IDX;
        wr_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_key();
        test_corner_blocks();
        test_random_traffic(23, {$urandom, $urandom, $urandom, $urandom}, 250);
        test_random_traffic(79, {32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom}, 250);
        test_random_traffic(0, {$urandom, $urandom, $urandom, $urandom}, 250);

        drain();
        repeat (2 * ROUNDS + 8) @(posedge clk);
        if (mismatch_count == 0 && expected_blocks.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
